// File: src/scfp_pkg.sv
// Shared types and constants for the sync/command frame parser.
package scfp_pkg;

   localparam int MAX_PAYLOAD = 32;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 6;
   localparam int IDX_W       = 5;
   localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SYNC     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_SYNC    = 2'd2;

   localparam logic [LEN_W-1:0]  RST_PAYLOAD_LENGTH = 6'd8;
   localparam logic [BYTE_W-1:0] RST_FIRST_SYNC     = 8'hAA;
   localparam logic [BYTE_W-1:0] RST_SECOND_SYNC    = 8'hBB;

   typedef enum logic [2:0] {
      ST_SYNC1,
      ST_SYNC2,
      ST_CMD,
      ST_DATA,
      ST_SUM,
      ST_DRAIN
   } state_type;

   // Read request from the sequencer, with the fields that travel with it
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [IDX_W-1:0]  index;
      logic              last;
      logic [BYTE_W-1:0] command;
   } rd_req_type;

endpackage

// File: src/scfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/scfp_seq.sv
// Frame sequencer: sync hunt, payload capture, checksum and payload drain.
module scfp_seq
   import scfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_byte_in,
   input  logic [LEN_W-1:0]  cfg_payload_length,
   input  logic [BYTE_W-1:0] cfg_first_sync,
   input  logic [BYTE_W-1:0] cfg_second_sync,
   input  logic              out_free,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [BYTE_W-1:0] wr_data,
   output rd_req_type        rd_req
);

   state_type         state_ff, state_in;
   logic [BYTE_W-1:0] command_ff, command_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  drain_ff, drain_in;
   logic [LEN_W:0]    len_ext;
   logic [CNT_W-1:0]  eff_len;
   logic [CNT_W-1:0]  fill_inc;
   logic [CNT_W-1:0]  drain_inc;
   logic              req_fire;

   // Length 0 counts as 1, anything above the store size is clamped
   always_comb begin
      len_ext = {1'b0, cfg_payload_length};
      if (len_ext == '0) begin
         eff_len = CNT_W'(1);
      end else if (len_ext > (LEN_W + 1)'(MAX_PAYLOAD)) begin
         eff_len = CNT_W'(MAX_PAYLOAD);
      end else begin
         eff_len = CNT_W'(len_ext);
      end
   end

   assign req_ready = (state_ff != ST_DRAIN);
   assign req_fire  = req_valid && req_ready;
   assign fill_inc  = fill_ff + CNT_W'(1);
   assign drain_inc = drain_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_SYNC1;
         command_ff <= '0;
         xor_ff     <= '0;
         fill_ff    <= '0;
         drain_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         command_ff <= command_in;
         xor_ff     <= xor_in;
         fill_ff    <= fill_in;
         drain_ff   <= drain_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      command_in = command_ff;
      xor_in     = xor_ff;
      fill_in    = fill_ff;
      drain_in   = drain_ff;
      wr_en      = 1'b0;
      wr_addr    = fill_ff[ADDR_W-1:0];
      wr_data    = req_byte_in;
      rd_req.en      = 1'b0;
      rd_req.addr    = drain_ff[ADDR_W-1:0];
      rd_req.index   = IDX_W'(drain_ff);
      rd_req.last    = (drain_inc == fill_ff);
      rd_req.command = command_ff;

      case (state_ff)
         ST_SYNC1: begin
            if (req_fire) begin
               state_in = (req_byte_in == cfg_first_sync) ? ST_SYNC2 : ST_SYNC1;
            end
         end
         ST_SYNC2: begin
            // a mismatch is not reconsidered as a first sync byte
            if (req_fire) begin
               state_in = (req_byte_in == cfg_second_sync) ? ST_CMD : ST_SYNC1;
            end
         end
         ST_CMD: begin
            if (req_fire) begin
               command_in = req_byte_in;
               xor_in     = req_byte_in;
               fill_in    = '0;
               state_in   = ST_DATA;
            end
         end
         ST_DATA: begin
            if (req_fire) begin
               wr_en   = 1'b1;
               fill_in = fill_inc;
               xor_in  = xor_ff ^ req_byte_in;
               if (fill_inc >= eff_len) begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            if (req_fire) begin
               drain_in = '0;
               if ((xor_ff ^ BYTE_W'(fill_ff)) == req_byte_in) begin
                  state_in = ST_DRAIN;
               end else begin
                  state_in = ST_SYNC1;
               end
            end
         end
         ST_DRAIN: begin
            // one store read per free output slot
            if (out_free) begin
               rd_req.en = 1'b1;
               drain_in  = drain_inc;
               if (drain_inc == fill_ff) begin
                  state_in = ST_SYNC1;
               end
            end
         end
         default: begin
            state_in = ST_SYNC1;
         end
      endcase
   end

   a_read_only_in_drain: assert property (@(posedge clock) disable iff (reset)
      rd_req.en |-> (state_ff == ST_DRAIN && out_free))
      else $error("store read outside drain");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(MAX_PAYLOAD))
      else $error("fill count beyond store size");

   a_drain_below_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (drain_ff < fill_ff))
      else $error("drain index past frame end");

   a_fill_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DATA && req_fire) |=> (fill_ff == $past(fill_inc)))
      else $error("fill count did not advance on payload item");

   a_last_ends_drain: assert property (@(posedge clock) disable iff (reset)
      (rd_req.en && rd_req.last) |=> (state_ff == ST_SYNC1))
      else $error("drain continued after last entry");

endmodule

// File: src/sync_cmd_frame_parser_xor.sv
// Top level: byte-stream frame parser with two sync bytes and XOR checksum.
//
// Input channel req_*: one received byte per item (req_byte_in). The parser hunts
// for the first then second sync byte, takes a command byte, payload_length
// payload bytes into a 32-entry store and a checksum byte (XOR of command,
// length and payload). A frame whose checksum matches is emitted on rsp_*,
// one item per payload byte with command, index, byte and a last flag; a
// bad frame is dropped without any output.
// Outside the drain req_ready is high and any byte offered is taken. After a
// good checksum byte the block stops taking input while the store is drained:
// one result per cycle while rsp_ready is high, until every payload byte has
// been read out. The first result is read once the sequencer is in its drain
// state and reaches rsp_* through the store read register and output register.
// The output register holds a result until it is taken; a stalled receiver
// stalls the drain, and with it the input, but parsing resumes as soon as
// the final result has been read out of the store.
// Configuration writes on csr_* are always ready and are meant for idle
// periods. Reset restores the default sync bytes (0xAA, 0xBB), a length of
// eight and the hunt for the first sync byte; the store is not cleared.
module sync_cmd_frame_parser_xor
   import scfp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BYTE_W-1:0]    req_byte_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BYTE_W-1:0]    rsp_command,
   output logic [IDX_W-1:0]     rsp_byte_index,
   output logic [BYTE_W-1:0]    rsp_payload_byte,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata
);

   logic [LEN_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0] sync1_ff, sync1_in;
   logic [BYTE_W-1:0] sync2_ff, sync2_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_command_ff, rsp_command_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              out_free;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;
   rd_req_type        rd_req;

   assign csr_ready = 1'b1;

   always_comb begin
      len_in   = len_ff;
      sync1_in = sync1_ff;
      sync2_in = sync2_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PAYLOAD_LENGTH: len_in   = csr_wdata[LEN_W-1:0];
            CSR_FIRST_SYNC:     sync1_in = csr_wdata;
            CSR_SECOND_SYNC:    sync2_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= RST_PAYLOAD_LENGTH;
         sync1_ff <= RST_FIRST_SYNC;
         sync2_ff <= RST_SECOND_SYNC;
      end else begin
         len_ff   <= len_in;
         sync1_ff <= sync1_in;
         sync2_ff <= sync2_in;
      end
   end

   scfp_seq u_seq (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_byte_in        (req_byte_in),
      .cfg_payload_length (len_ff),
      .cfg_first_sync     (sync1_ff),
      .cfg_second_sync    (sync2_ff),
      .out_free           (out_free),
      .wr_en              (wr_en),
      .wr_addr            (wr_addr),
      .wr_data            (wr_data),
      .rd_req             (rd_req)
   );

   // Read data stays put between reads, so it serves as the output payload
   scfp_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_PAYLOAD)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_req.en),
      .rd_addr (rd_req.addr),
      .rd_data (rsp_payload_byte)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_command_in = rsp_command_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_last_in    = rsp_last_ff;
      if (rd_req.en) begin
         rsp_valid_in   = 1'b1;
         rsp_command_in = rd_req.command;
         rsp_index_in   = rd_req.index;
         rsp_last_in    = rd_req.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_command_ff <= rsp_command_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_command    = rsp_command_ff;
   assign rsp_byte_index = rsp_index_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// File: verif/tb_top.sv
// Testbench for sync_cmd_frame_parser_xor: directed plan, then random frames.
`timescale 1ns / 100ps

module tb_top;
   import scfp_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic                 BYTE_ROW   = 1'b0;
   localparam logic                 CSR_ROW    = 1'b1;
   localparam logic [7:0]           NO_CHECK   = 8'hFF;
   localparam int                   PLAN_ROWS  = 37;
   localparam int                   RANDOM_ITEMS = 300;

   typedef struct packed {
      logic [BYTE_W-1:0] command;
      logic [IDX_W-1:0]  byte_index;
      logic [BYTE_W-1:0] payload_byte;
      logic              last;
   } frame_byte_type;

   typedef struct packed {
      logic                 is_csr;
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [7:0]           value;
      logic [7:0]           n_results;   // results caused by this byte, or NO_CHECK
   } plan_row_type;

   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic [BYTE_W-1:0]    req_byte_in      = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b1;
   logic [BYTE_W-1:0]    rsp_command;
   logic [IDX_W-1:0]     rsp_byte_index;
   logic [BYTE_W-1:0]    rsp_payload_byte;
   logic                 rsp_last;
   logic                 csr_valid        = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index        = CSR_PAYLOAD_LENGTH;
   logic [BYTE_W-1:0]    csr_wdata        = '0;

   // parser copy: configuration and frame state
   logic [LEN_W-1:0]  cfg_len;
   logic [BYTE_W-1:0] sync_a;
   logic [BYTE_W-1:0] sync_b;
   state_type         hunt_state;
   logic [BYTE_W-1:0] frame_cmd;
   logic [BYTE_W-1:0] run_xor;
   logic [6:0]        fill;
   logic [BYTE_W-1:0] store_copy [MAX_PAYLOAD];
   frame_byte_type    frame_bytes_due [$];

   int             errors       = 0;
   int             last_results = 0;
   int             items_sent   = 0;
   int             burst_left   = 0;
   int             rx_cycle     = 0;
   frame_byte_type head;

   plan_row_type directed_plan [0:PLAN_ROWS-1] = '{
      // reset settings: sync AA BB, eight payload bytes, extremes
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'hAA, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'hBB, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'hFF, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'h00, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'hFF, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'h00, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'hFF, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'h00, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'hFF, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'h00, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'hFF, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'hF7, 8'd8},
      // length 0 (upper bits set) acts as 1; unused register index
      '{CSR_ROW,  CSR_PAYLOAD_LENGTH, 8'hC0, NO_CHECK},
      '{CSR_ROW,  CSR_UNUSED,         8'h5A, NO_CHECK},
      // second byte wrong although equal to the first sync value
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'hAA, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'hAA, 8'd0},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'hAA, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'hBB, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'h00, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'h80, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'h81, 8'd1},
      // bad checksum, frame dropped
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'hAA, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'hBB, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'h12, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'h34, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'h00, 8'd0},
      // sync extremes, then length cut from 3 to 2 with two bytes already in
      '{CSR_ROW,  CSR_FIRST_SYNC,     8'h00, NO_CHECK},
      '{CSR_ROW,  CSR_SECOND_SYNC,    8'hFF, NO_CHECK},
      '{CSR_ROW,  CSR_PAYLOAD_LENGTH, 8'h03, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'h00, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'hFF, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'h5A, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'h11, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'h22, NO_CHECK},
      '{CSR_ROW,  CSR_PAYLOAD_LENGTH, 8'h02, NO_CHECK},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'h33, 8'd0},
      '{BYTE_ROW, CSR_PAYLOAD_LENGTH, 8'h59, 8'd3}
   };

   sync_cmd_frame_parser_xor i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_in      (req_byte_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_command      (rsp_command),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      errors++;
   endtask

   function automatic int active_length();
      if (cfg_len == 0)
         return 1;
      if (cfg_len > MAX_PAYLOAD)
         return MAX_PAYLOAD;
      return cfg_len;
   endfunction

   // Advance the parser copy by one byte; queue any frame it completes.
   function automatic int parse_rx_byte(input logic [BYTE_W-1:0] b);
      int             n;
      frame_byte_type r;
      n = 0;
      case (hunt_state)
         ST_SYNC2: hunt_state = (b == sync_b) ? ST_CMD : ST_SYNC1;
         ST_CMD: begin
            frame_cmd  = b;
            run_xor    = b;
            fill       = '0;
            hunt_state = ST_DATA;
         end
         ST_DATA: begin
            if (fill < MAX_PAYLOAD) begin
               store_copy[fill[ADDR_W-1:0]] = b;
               fill++;
            end
            run_xor = run_xor ^ b;
            if (fill >= active_length())
               hunt_state = ST_SUM;
         end
         ST_SUM: begin
            hunt_state = ST_SYNC1;
            if ((run_xor ^ {1'b0, fill}) == b) begin
               for (int k = 0; k < fill; k++) begin
                  r.command      = frame_cmd;
                  r.byte_index   = k[IDX_W-1:0];
                  r.payload_byte = store_copy[k[ADDR_W-1:0]];
                  r.last         = (k + 1 == fill);
                  frame_bytes_due.push_back(r);
                  n++;
               end
            end
         end
         default: hunt_state = (b == sync_a) ? ST_SYNC2 : ST_SYNC1;
      endcase
      return n;
   endfunction

   // Results are checked before the byte accepted on the same edge is parsed.
   always @(posedge clock) begin
      if (reset) begin
         cfg_len    = RST_PAYLOAD_LENGTH;
         sync_a     = RST_FIRST_SYNC;
         sync_b     = RST_SECOND_SYNC;
         hunt_state = ST_SYNC1;
         frame_cmd  = '0;
         run_xor    = '0;
         fill       = '0;
         frame_bytes_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frame_bytes_due.size() == 0) begin
               report_mismatch($sformatf("result with none due: cmd %h index %0d",
                                         rsp_command, rsp_byte_index));
            end else begin
               head = frame_bytes_due.pop_front();
               if (rsp_command !== head.command)
                  report_mismatch($sformatf("command %h, expected %h",
                                            rsp_command, head.command));
               if (rsp_byte_index !== head.byte_index)
                  report_mismatch($sformatf("byte_index %0d, expected %0d",
                                            rsp_byte_index, head.byte_index));
               if (rsp_payload_byte !== head.payload_byte)
                  report_mismatch($sformatf("payload_byte %h, expected %h at index %0d",
                                            rsp_payload_byte, head.payload_byte,
                                            head.byte_index));
               if (rsp_last !== head.last)
                  report_mismatch($sformatf("last %b, expected %b at index %0d",
                                            rsp_last, head.last, head.byte_index));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PAYLOAD_LENGTH: cfg_len = csr_wdata[LEN_W-1:0];
               CSR_FIRST_SYNC:     sync_a  = csr_wdata;
               CSR_SECOND_SYNC:    sync_b  = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            last_results = parse_rx_byte(req_byte_in);
      end
   end

   // receiver: always ready, random, one stall in four, then long stalls
   always @(negedge clock) begin
      rx_cycle++;
      case ((rx_cycle / 150) % 4)
         0:       rsp_ready = 1'b1;
         1:       rsp_ready = ($urandom_range(0, 2) != 0);
         2:       rsp_ready = ((rx_cycle % 4) != 3);
         default: rsp_ready = ((rx_cycle % 11) >= 7);
      endcase
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid   = 1'b1;
      req_byte_in = b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // Hold the input off until every queued result is out and the block has settled.
   task automatic wait_drained();
      req_valid = 1'b0;
      while (frame_bytes_due.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] data);
      wait_drained();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Feed filler until the parser is back to hunting for the first sync byte.
   task automatic resync();
      logic [BYTE_W-1:0] b;
      while (hunt_state != ST_SYNC1) begin
         b = BYTE_W'($urandom);
         if (b == sync_b)
            b = ~b;
         send_byte(b);
      end
   endtask

   task automatic send_frame(input logic corrupt);
      logic [BYTE_W-1:0] cmd;
      logic [BYTE_W-1:0] d;
      logic [BYTE_W-1:0] sum;
      int                n;
      n = active_length();
      resync();
      send_byte(sync_a);
      send_byte(sync_b);
      cmd = BYTE_W'($urandom);
      send_byte(cmd);
      sum = cmd ^ n[BYTE_W-1:0];
      for (int i = 0; i < n; i++) begin
         d = BYTE_W'($urandom);
         sum = sum ^ d;
         send_byte(d);
      end
      if (corrupt)
         sum = sum ^ (8'h01 << $urandom_range(0, 7));
      send_byte(sum);
   endtask

   // Broken start: first sync, then a wrong second byte, then the second sync value.
   task automatic send_broken_sync();
      logic [BYTE_W-1:0] b;
      resync();
      send_byte(sync_a);
      b = BYTE_W'($urandom);
      if ($urandom_range(0, 1) == 0)
         b = sync_a;
      if (b == sync_b)
         b = ~b;
      send_byte(b);
      send_byte(sync_b);
   endtask

   task automatic configure_phase(input int ph);
      logic [7:0] len_w;
      logic [7:0] a;
      logic [7:0] b;
      case (ph % 6)
         0: len_w = 8'd1;
         1: len_w = 8'd32;
         2: begin
            len_w      = 8'($urandom);
            len_w[5:0] = 6'd0;
         end
         3: len_w = (ph % 12 == 3) ? 8'hFF : 8'h21;
         default: len_w = 8'($urandom_range(2, 6));
      endcase
      a = 8'($urandom);
      b = 8'($urandom);
      case ($urandom_range(0, 5))
         0: b = a;
         1: begin
            a = 8'h00;
            b = 8'hFF;
         end
         2: begin
            a = 8'hFF;
            b = 8'h00;
         end
         default: ;
      endcase
      write_csr(CSR_PAYLOAD_LENGTH, len_w);
      write_csr(CSR_FIRST_SYNC, a);
      write_csr(CSR_SECOND_SYNC, b);
      if ($urandom_range(0, 3) == 0)
         write_csr(CSR_UNUSED, 8'($urandom));
   endtask

   initial begin : stimulus
      int           goal;
      int           ph;
      int           frames;
      int           pick;
      plan_row_type row;
      logic [7:0]   b;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < PLAN_ROWS; i++) begin
         row = directed_plan[i];
         if (row.is_csr) begin
            write_csr(row.reg_idx, row.value);
         end else begin
            send_byte(row.value);
            if (row.n_results != NO_CHECK && last_results != row.n_results)
               report_mismatch($sformatf("byte %h gave %0d results, expected %0d",
                                         row.value, last_results, row.n_results));
         end
      end

      goal = items_sent + RANDOM_ITEMS;
      ph = 0;
      while (items_sent < goal) begin
         configure_phase(ph);
         frames = (active_length() >= 16) ? 1 : $urandom_range(5, 9);
         for (int f = 0; f < frames; f++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
               send_frame(1'b0);
            else if (pick < 80)
               send_frame(1'b1);
            else if (pick < 88) begin
               repeat ($urandom_range(1, 4)) begin
                  b = 8'($urandom);
                  send_byte(b);
               end
            end else
               send_broken_sync();
            if ($urandom_range(0, 19) == 0)
               wait_drained();
         end
         // sometimes leave a frame open so the next length lands mid-frame
         if (active_length() > 1 && $urandom_range(0, 4) < 2) begin
            resync();
            send_byte(sync_a);
            send_byte(sync_b);
            repeat ($urandom_range(1, active_length())) begin
               b = 8'($urandom);
               send_byte(b);
            end
         end
         ph++;
      end

      wait_drained();
      repeat (40) @(negedge clock);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// File: filelist.f
src/scfp_pkg.sv
src/scfp_ram.sv
src/scfp_seq.sv
src/sync_cmd_frame_parser_xor.sv
verif/tb_top.sv
